>>> rtl/lsd_pkg.sv
// ----------------------------------------------------------------------------
// lsd_pkg: shared types and helpers for the spring damper step
// Q16.16 types, register indexes, reset values, sequencer states and the
// saturating product post-processing used by the datapath.
// ----------------------------------------------------------------------------
package lsd_pkg;

  typedef logic signed [31:0] q_t;     // Q16.16 signed value
  typedef logic signed [63:0] wide_t;  // full product / widened sum
  typedef logic [30:0]        coef_t;  // unsigned multiplier coefficient

  localparam int unsigned NumAxes = 3;
  localparam int unsigned AxisW   = $clog2(NumAxes);
  localparam int unsigned CfgW    = 31;
  localparam int unsigned DtW     = 17;

  typedef logic [AxisW-1:0] axis_t;
  localparam axis_t AxisLast = axis_t'(NumAxes - 1);

  typedef enum logic [1:0] {
    REG_STIFFNESS = 2'd0,
    REG_DAMPING   = 2'd1,
    REG_MASS_INV  = 2'd2,
    REG_TIME_STEP = 2'd3
  } lsd_reg_e;

  localparam coef_t          StiffnessRst = coef_t'(0);
  localparam coef_t          DampingRst   = coef_t'(0);
  localparam coef_t          MassInvRst   = coef_t'(65536);
  localparam logic [DtW-1:0] TimeStepRst  = DtW'(1092);

  localparam wide_t SatHi = 64'sh0000_0000_7FFF_FFFF;
  localparam wide_t SatLo = -64'sh0000_0000_8000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISP,   // displacement, start vel*c
    ST_SPRK,   // damping term, start disp*k
    ST_TOTAL,  // total force
    ST_MULM,   // start total*inv_mass
    ST_ACCM,   // acceleration, start accel*dt
    ST_VEL,    // new velocity
    ST_POSM,   // start vel*dt
    ST_POS,    // new position, next axis
    ST_DONE    // hand result to output register
  } lsd_state_e;

  // clamp to the signed 32-bit range
  function automatic q_t sat_q(wide_t v);
    q_t r;
    if (v > SatHi) begin
      r = q_t'(SatHi[31:0]);
    end else if (v < SatLo) begin
      r = q_t'(SatLo[31:0]);
    end else begin
      r = q_t'(v[31:0]);
    end
    return r;
  endfunction

  // arithmetic shift of a Q32.32 product back to Q16.16, optional negate, clamp
  function automatic q_t q_post(wide_t prod, logic negate);
    wide_t sh;
    sh = prod >>> 16;
    if (negate) begin
      sh = -sh;
    end
    return sat_q(sh);
  endfunction

endpackage

>>> rtl/linear_spring_damper_step.sv
// ----------------------------------------------------------------------------
// linear_spring_damper_step: three-axis damped spring, one Euler substep
// Keeps position and velocity per axis and advances them by one
// semi-implicit Euler substep for every input transaction.
// ----------------------------------------------------------------------------
// One input transaction carries the rest position and the external force of
// a substep; one output transaction returns the new position and velocity.
// All values are Q16.16; every intermediate saturates to 32 bits. A single
// 32x31 multiplier is shared by all five products of an axis, so the
// sequencer walks eight steps per axis. The result is loaded into the output
// register in the final hand-off step, which follows the steps of all three
// axes and also returns to idle; the next transaction is accepted from idle.
// in_stall_o stays high while an item is in flight. The output register
// decouples the two sides: a new transaction is accepted while the previous
// result still waits, and the sequencer only parks in its final step if that
// earlier result has not been taken by then. Registers are written through
// cfg_*; the user must write them only while the block is idle, which the
// block itself does not enforce.
// ----------------------------------------------------------------------------
module linear_spring_damper_step import lsd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  // configuration
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i,
  // input channel
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  q_t              rest_x_i,
  input  q_t              rest_y_i,
  input  q_t              rest_z_i,
  input  q_t              force_x_i,
  input  q_t              force_y_i,
  input  q_t              force_z_i,
  // output channel
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output q_t              pos_x_o,
  output q_t              pos_y_o,
  output q_t              pos_z_o,
  output q_t              vel_x_o,
  output q_t              vel_y_o,
  output q_t              vel_z_o
);

  // configuration registers
  coef_t          stiff_q, damp_c_q, minv_q;
  logic [DtW-1:0] dt_q;

  // sequencer
  lsd_state_e state_q, state_d;
  axis_t      axis_q, axis_d;

  // state of the spring, one entry per axis
  q_t pos_q [NumAxes];
  q_t vel_q [NumAxes];
  logic pos_we, vel_we;
  q_t   pos_wd, vel_wd;

  // latched input transaction
  q_t rest_q  [NumAxes];
  q_t force_q [NumAxes];

  // per-axis intermediates
  q_t disp_q, disp_d;
  q_t damp_q, damp_d;
  q_t total_q, total_d;

  // output register
  logic out_valid_q, out_valid_d;
  q_t   res_pos_q [NumAxes];
  q_t   res_vel_q [NumAxes];
  logic res_load;

  // shared multiplier
  logic  mul_en;
  q_t    mul_a;
  coef_t mul_b;
  wide_t prod;

  logic in_acc, out_acc;
  coef_t dt_coef;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_q && !out_stall_i;
  assign dt_coef = coef_t'(dt_q);

  assign in_stall_o = (state_q != ST_IDLE);

  lsd_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stiff_q  <= StiffnessRst;
      damp_c_q <= DampingRst;
      minv_q   <= MassInvRst;
      dt_q     <= TimeStepRst;
    end else if (cfg_we_i) begin
      case (lsd_reg_e'(cfg_idx_i))
        REG_STIFFNESS: stiff_q  <= cfg_data_i;
        REG_DAMPING:   damp_c_q <= cfg_data_i;
        REG_MASS_INV:  minv_q   <= cfg_data_i;
        REG_TIME_STEP: dt_q     <= cfg_data_i[DtW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and datapath control
  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    disp_d      = disp_q;
    damp_d      = damp_q;
    total_d     = total_q;
    mul_en      = 1'b0;
    mul_a       = vel_q[axis_q];
    mul_b       = damp_c_q;
    pos_we      = 1'b0;
    vel_we      = 1'b0;
    pos_wd      = pos_q[axis_q];
    vel_wd      = vel_q[axis_q];
    res_load    = 1'b0;
    out_valid_d = out_valid_q && !out_acc;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          axis_d  = '0;
          state_d = ST_DISP;
        end
      end
      ST_DISP: begin
        // displacement from rest, and vel*c on the multiplier
        disp_d  = sat_q(wide_t'(pos_q[axis_q]) - wide_t'(rest_q[axis_q]));
        mul_en  = 1'b1;
        mul_a   = vel_q[axis_q];
        mul_b   = damp_c_q;
        state_d = ST_SPRK;
      end
      ST_SPRK: begin
        damp_d  = q_post(prod, 1'b1);
        mul_en  = 1'b1;
        mul_a   = disp_q;
        mul_b   = stiff_q;
        state_d = ST_TOTAL;
      end
      ST_TOTAL: begin
        // spring + damping + external force, one clamp over the three-way sum
        total_d = sat_q(wide_t'(q_post(prod, 1'b1)) + wide_t'(damp_q)
                        + wide_t'(force_q[axis_q]));
        state_d = ST_MULM;
      end
      ST_MULM: begin
        mul_en  = 1'b1;
        mul_a   = total_q;
        mul_b   = minv_q;
        state_d = ST_ACCM;
      end
      ST_ACCM: begin
        mul_en  = 1'b1;
        mul_a   = q_post(prod, 1'b0);
        mul_b   = dt_coef;
        state_d = ST_VEL;
      end
      ST_VEL: begin
        vel_we  = 1'b1;
        vel_wd  = sat_q(wide_t'(vel_q[axis_q]) + wide_t'(q_post(prod, 1'b0)));
        state_d = ST_POSM;
      end
      ST_POSM: begin
        // uses the velocity just written
        mul_en  = 1'b1;
        mul_a   = vel_q[axis_q];
        mul_b   = dt_coef;
        state_d = ST_POS;
      end
      ST_POS: begin
        pos_we = 1'b1;
        pos_wd = sat_q(wide_t'(pos_q[axis_q]) + wide_t'(q_post(prod, 1'b0)));
        if (axis_q == AxisLast) begin
          state_d = ST_DONE;
        end else begin
          axis_d  = axis_q + axis_t'(1);
          state_d = ST_DISP;
        end
      end
      ST_DONE: begin
        // wait only while an earlier result is still pending downstream
        if (!(out_valid_q && out_stall_i)) begin
          res_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumAxes; i++) begin
        pos_q[i] <= '0;
        vel_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
      if (pos_we) begin
        pos_q[axis_q] <= pos_wd;
      end
      if (vel_we) begin
        vel_q[axis_q] <= vel_wd;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    disp_q  <= disp_d;
    damp_q  <= damp_d;
    total_q <= total_d;
    if (in_acc) begin
      rest_q[0]  <= rest_x_i;
      rest_q[1]  <= rest_y_i;
      rest_q[2]  <= rest_z_i;
      force_q[0] <= force_x_i;
      force_q[1] <= force_y_i;
      force_q[2] <= force_z_i;
    end
    if (res_load) begin
      for (int i = 0; i < NumAxes; i++) begin
        res_pos_q[i] <= pos_q[i];
        res_vel_q[i] <= vel_q[i];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = res_pos_q[0];
  assign pos_y_o     = res_pos_q[1];
  assign pos_z_o     = res_pos_q[2];
  assign vel_x_o     = res_vel_q[0];
  assign vel_y_o     = res_vel_q[1];
  assign vel_z_o     = res_vel_q[2];

  // an accepted transaction always starts on the first axis
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_DISP) && (axis_q == '0))
    else $error("sequencer did not start on first axis");

  // axis counter stays inside the state arrays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    axis_q <= AxisLast)
    else $error("axis counter out of range");

  // a new result only appears from the final step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result valid raised outside final step");

  // a pending result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) && out_valid_q && out_stall_i |=> (state_q == ST_DONE))
    else $error("pending result overwritten");

endmodule

>>> rtl/lsd_mul.sv
// ----------------------------------------------------------------------------
// lsd_mul: shared multiplier
// Signed 32-bit operand times unsigned 31-bit coefficient, product registered.
// ----------------------------------------------------------------------------
module lsd_mul import lsd_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  q_t    a_i,
  input  coef_t b_i,
  output wide_t prod_o
);

  wide_t prod_q, prod_d;
  logic signed [31:0] b_s;

  assign b_s    = signed'({1'b0, b_i});
  assign prod_d = wide_t'(a_i) * wide_t'(b_s);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule
